// ===== design/spiq_pkg.sv =====
// Shared types and codes for the stable priority insert queue.
// No dependencies; imported by every module of the block except spiq_fifo.
package spiq_pkg;

  localparam int unsigned IN_TAG_W   = 16;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned SLOT_W     = 4;
  localparam int          LIST_CAP   = 16;

  typedef enum logic {
    OPC_INSERT = 1'b0,
    OPC_LIST   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STS_INSERTED = 2'd0,
    STS_DROPPED  = 2'd1,
    STS_LISTED   = 2'd2,
    STS_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_LIST
  } state_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [IN_TAG_W-1:0]   arrival_tag;
    logic [LEVEL_W-1:0]    level;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [IN_TAG_W-1:0]   out_tag;
    logic [LEVEL_W-1:0]    out_level;
    logic [SLOT_W-1:0]     slot;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    opcode_t               op;
    logic [IN_TAG_W-1:0]   tag;
    logic [LEVEL_W-1:0]    level;
  } cmd_t;

endpackage

// ===== design/spiq_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
// Depends on nothing but its type parameter.
module spiq_fifo #(
  parameter type         T = logic,
  parameter int unsigned N = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic empty
);

  localparam int unsigned PW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = $clog2(N + 1);

  T                mem_r [N];
  logic [PW-1:0]   wptr_r;
  logic [PW-1:0]   rptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr;
  logic            do_rd;

  assign full    = (cnt_r == CW'(N));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PW'(N - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PW'(N - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== design/spiq_front.sv =====
// Front end: accepts input beats, decodes them into commands and queues them.
// Depends on spiq_pkg and spiq_fifo.
module spiq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  spiq_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output spiq_pkg::cmd_t    cmd
);
  import spiq_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  always_comb begin
    cmd_in.op    = in_data.opcode;
    cmd_in.tag   = (in_data.opcode == OPC_INSERT) ? in_data.arrival_tag : '0;
    cmd_in.level = (in_data.opcode == OPC_INSERT) ? in_data.level : '0;
  end

  spiq_fifo #(.T(cmd_t), .N(2)) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

// ===== design/spiq_back.sv =====
// Back end: sorted cell array with parallel insert, rotating list sequencer
// and the result queue. Depends on spiq_pkg and spiq_fifo.
module spiq_back #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  spiq_pkg::cmd_t      cmd,
  output logic                empty,
  input  logic                pop,
  output spiq_pkg::out_item_t out_data
);
  import spiq_pkg::*;

  localparam int unsigned KB = (TAG_BITS < IN_TAG_W) ? TAG_BITS : IN_TAG_W;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  logic [KB-1:0]      tag_r [DEPTH];
  logic [LEVEL_W-1:0] lvl_r [DEPTH];
  logic [DEPTH-1:0]   at_r;
  logic [DEPTH-1:0]   at_nxt;
  logic [DEPTH-1:0]   le;
  logic [DEPTH-1:0]   shift_in;
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [IW-1:0]      slot_enc;
  state_t             state_r, state_nxt;
  logic               do_ins;
  logic               do_rot;
  logic               res_push;
  logic               res_full;
  out_item_t          res;
  int                 list_n;
  logic               emit;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CW'(i) < count_r) && (lvl_r[i] <= cmd.level);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        at_nxt[i]   = !le[i];
        shift_in[i] = 1'b0;
      end else begin
        at_nxt[i]   = le[i-1] && !le[i];
        shift_in[i] = !le[i-1] && (CW'(i - 1) < count_r);
      end
    end
  end

  always_comb begin
    slot_enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (at_r[i]) begin
        slot_enc = slot_enc | IW'(i);
      end
    end
  end

  assign list_n = (int'(count_r) < LIST_CAP) ? int'(count_r) : LIST_CAP;
  assign emit   = int'(idx_r) < LIST_CAP;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    cmd_pop   = 1'b0;
    do_ins    = 1'b0;
    do_rot    = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd.op == OPC_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              res_push   = 1'b1;
              res.status = STS_DROPPED;
            end else begin
              do_ins    = 1'b1;
              count_nxt = count_r + CW'(1);
              state_nxt = S_SLOT;
            end
          end else if (count_r == '0) begin
            res_push   = 1'b1;
            res.status = STS_EMPTY;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_LIST;
          end
        end
      end
      S_SLOT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res.status = STS_INSERTED;
          res.slot   = SLOT_W'(slot_enc);
          state_nxt  = S_IDLE;
        end
      end
      S_LIST: begin
        if (!emit || !res_full) begin
          do_rot = 1'b1;
          if (emit) begin
            res_push      = 1'b1;
            res.status    = STS_LISTED;
            res.out_tag   = IN_TAG_W'(tag_r[0]);
            res.out_level = lvl_r[0];
            res.slot      = SLOT_W'(idx_r);
            res.last      = (int'(idx_r) + 1 == list_n);
          end
          if (CW'(idx_r) + CW'(1) == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      at_r <= at_nxt;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (do_ins) begin
        if (at_nxt[i]) begin
          tag_r[i] <= cmd.tag[KB-1:0];
          lvl_r[i] <= cmd.level;
        end else if (shift_in[i]) begin
          tag_r[i] <= tag_r[(i + DEPTH - 1) % DEPTH];
          lvl_r[i] <= lvl_r[(i + DEPTH - 1) % DEPTH];
        end
      end else if (do_rot) begin
        if (CW'(i + 1) < count_r) begin
          tag_r[i] <= tag_r[(i + 1) % DEPTH];
          lvl_r[i] <= lvl_r[(i + 1) % DEPTH];
        end else if (CW'(i + 1) == count_r) begin
          tag_r[i] <= tag_r[0];
          lvl_r[i] <= lvl_r[0];
        end
      end
    end
  end

  spiq_fifo #(.T(out_item_t), .N(2)) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule

// ===== design/stable_priority_insert_queue.sv =====
// Top level of the stable priority insert queue: front end, back end.
// Depends on spiq_pkg, spiq_front, spiq_back.
//
//   channel | ports                    | beat moves when
//   input   | push, full, in_data      | push && !full
//   result  | empty, pop, out_data     | pop && !empty
//
// Insert: parallel compare and shift of all cells in S_IDLE, then slot encode
// in S_SLOT. Full insert or empty list: answered straight from S_IDLE. List:
// started from S_IDLE, then S_LIST steps through the stored entries by rotating
// the cell array through cell 0; only the first 16 produce beats.
// Reset clears the entry count and queues; cell contents are left as they are.
// Two-deep queues on both sides let input and result sides stall independently.
module stable_priority_insert_queue #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  spiq_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output spiq_pkg::out_item_t out_data
);
  import spiq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  spiq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  spiq_back #(.DEPTH(DEPTH), .TAG_BITS(TAG_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
